// File: hw/rtl/sexpr_token_lexer_unit_defines.svh
// Assertion macros for the s-expression token lexer.
// Each macro expects clk and rst_n in scope and ends its own statement.
`ifndef SEXPR_TOKEN_LEXER_UNIT_DEFINES_SVH
`define SEXPR_TOKEN_LEXER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define STL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexer check failed");
`define STL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexer check failed");
`else
`define STL_ASSERT_NOW(lbl, ante, cons)
`define STL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/stl_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_pkg
// Shared types, character codes and helpers of the token lexer.
// ---------------------------------------------------------------------------
package stl_pkg;

  localparam int MAX_DELIM_DEF = 8;
  localparam int MAX_RESULTS   = 12;
  localparam int QDEPTH        = 4;
  localparam int CNT_W         = 6;
  localparam logic [23:0] LINE_TOP = 24'hFFFFFF;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_LP    = 8'h28;
  localparam logic [7:0] CH_RP    = 8'h29;

  localparam logic [2:0] TK_EOF   = 3'd0;
  localparam logic [2:0] TK_OPEN  = 3'd1;
  localparam logic [2:0] TK_CLOSE = 3'd2;
  localparam logic [2:0] TK_INT   = 3'd3;
  localparam logic [2:0] TK_REAL  = 3'd4;
  localparam logic [2:0] TK_NAME  = 3'd5;
  localparam logic [2:0] TK_TEXT  = 3'd6;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_QUOTE = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;
  localparam logic [1:0] ERR_OVF   = 2'd3;

  localparam logic RK_DATA = 1'b0;
  localparam logic RK_END  = 1'b1;

  typedef enum logic [3:0] {
    M_SKIP, M_COMMENT, M_QUOTED, M_AFTERQ, M_OPENER, M_RAWFIRST, M_RAW,
    M_SIGN, M_INT, M_INTOVF, M_DOT, M_FRAC, M_NAME, M_NAMEBAD
  } lex_mode_t;

  // One request of result records: flush bytes, end, content, end, eof.
  typedef struct packed {
    logic [CNT_W-1:0] fl_cnt;
    logic [2:0]       fl_kind;
    logic [23:0]      line_a;
    logic [23:0]      line_b;
    logic [23:0]      line_e;
    logic             f1_vld;
    logic [2:0]       f1_kind;
    logic [63:0]      f1_val;
    logic [1:0]       f1_err;
    logic             c_vld;
    logic [2:0]       c_kind;
    logic [7:0]       c_byte;
    logic             f2_vld;
    logic [2:0]       f2_kind;
    logic             eof_vld;
  } cmd_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SP) || ((b >= CH_TAB) && (b <= CH_CR));
  endfunction

  function automatic logic is_delim(input logic [7:0] b);
    return is_space(b) || (b == CH_LP) || (b == CH_RP);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  function automatic logic [7:0] swap_slash(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CH_SLASH) r = CH_BSL;
    else if (b == CH_BSL) r = CH_SLASH;
    return r;
  endfunction

endpackage

// File: hw/rtl/stl_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_in_if
// Source byte channel of the token lexer.
// ---------------------------------------------------------------------------
interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;
  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink   (input valid, in_byte, end_of_input, output ready);
endinterface

// File: hw/rtl/stl_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_out_if
// Token record channel of the token lexer.
// ---------------------------------------------------------------------------
interface stl_out_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic [2:0]         token_kind;
  logic [7:0]         data_byte;
  logic [23:0]        token_line;
  logic signed [63:0] int_value;
  logic [1:0]         error_code;
  logic               last;
  modport source (output valid, record_kind, token_kind, data_byte, token_line,
                  int_value, error_code, last, input ready);
  modport sink   (input valid, record_kind, token_kind, data_byte, token_line,
                  int_value, error_code, last, output ready);
endinterface

// File: hw/rtl/stl_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_front
// Lexer state machine: classifies one byte per cycle into a record request while the queue is not full.
// ---------------------------------------------------------------------------
`include "sexpr_token_lexer_unit_defines.svh"
module stl_front #(
  parameter int MAX_DELIM = stl_pkg::MAX_DELIM_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stl_in_if.sink                      in_ch,
  input  logic                        q_full,
  output logic                        push,
  output stl_pkg::cmd_t               cmd,
  output logic [MAX_DELIM-1:0][7:0]   fl_data
);
  localparam int LEN_W = $clog2(MAX_DELIM + 1);
  localparam int IDX_W = $clog2(MAX_DELIM);

  stl_pkg::lex_mode_t mode_r, mode_nxt;
  logic [23:0] line_r, line_nxt, sline_r, sline_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        neg_r, neg_nxt, esc_r, esc_nxt;
  logic [7:0]  qch_r, qch_nxt;
  logic [MAX_DELIM-1:0][7:0] opn_r, opn_nxt, pat_r, pat_nxt, win_r, win_nxt, win_new;
  logic [LEN_W-1:0] olen_r, olen_nxt, wfill_r, wfill_nxt, wpos;
  logic        take, st, fl_src_win, raw_shift, raw_closed, ovf;
  logic [7:0]  b;
  logic [67:0] prod;
  logic [63:0] lim;

  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;
  assign b = in_ch.in_byte;
  assign fl_data = fl_src_win ? win_r : opn_r;

  // next value of the integer accumulator: acc*10 + digit, saturating
  always_comb begin
    lim  = neg_r ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    prod = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {64'b0, b[3:0]};
    ovf  = prod > {4'b0, lim};
  end

  // raw text window: shift out the oldest byte once full, then compare to closer
  always_comb begin
    raw_shift = (wfill_r >= olen_r);
    wpos = raw_shift ? olen_r - LEN_W'(1) : wfill_r;
    raw_closed = ((wpos + LEN_W'(1)) == olen_r);
    win_new = raw_shift ? (win_r >> 8) : win_r;
    win_new[wpos[IDX_W-1:0]] = b;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if ((LEN_W'(i) < olen_r) && (win_new[i] != pat_r[i])) raw_closed = 1'b0;
    end
  end

  always_comb begin
    mode_nxt = mode_r;  line_nxt = line_r;  sline_nxt = sline_r;
    acc_nxt = acc_r;    neg_nxt = neg_r;    esc_nxt = esc_r;   qch_nxt = qch_r;
    opn_nxt = opn_r;    pat_nxt = pat_r;    olen_nxt = olen_r;
    win_nxt = win_r;    wfill_nxt = wfill_r;
    cmd = '0;
    st = 1'b0;
    fl_src_win = 1'b0;
    if (!in_ch.end_of_input && (b == stl_pkg::CH_LF) && (line_r != stl_pkg::LINE_TOP))
      line_nxt = line_r + 24'd1;
    if (in_ch.end_of_input) begin
      unique case (mode_r)
        stl_pkg::M_QUOTED: begin
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_TEXT; cmd.f1_err = stl_pkg::ERR_QUOTE;
        end
        stl_pkg::M_AFTERQ: begin
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_TEXT;
        end
        stl_pkg::M_OPENER: begin
          cmd.fl_cnt = stl_pkg::CNT_W'(olen_r); cmd.fl_kind = stl_pkg::TK_NAME;
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_NAME;
        end
        stl_pkg::M_RAWFIRST, stl_pkg::M_RAW: begin
          fl_src_win = 1'b1;
          cmd.fl_cnt = stl_pkg::CNT_W'(wfill_r); cmd.fl_kind = stl_pkg::TK_TEXT;
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_TEXT;
        end
        stl_pkg::M_SIGN, stl_pkg::M_DOT, stl_pkg::M_NAME: begin
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_NAME;
        end
        stl_pkg::M_NAMEBAD: begin
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_NAME; cmd.f1_err = stl_pkg::ERR_LONG;
        end
        stl_pkg::M_INT, stl_pkg::M_INTOVF: begin
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_INT;
          cmd.f1_val = neg_r ? (64'd0 - acc_r) : acc_r;
          cmd.f1_err = (mode_r == stl_pkg::M_INTOVF) ? stl_pkg::ERR_OVF : stl_pkg::ERR_NONE;
        end
        stl_pkg::M_FRAC: begin
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_REAL;
        end
        default: ;
      endcase
      cmd.eof_vld = 1'b1;
      mode_nxt = stl_pkg::M_SKIP;
      wfill_nxt = '0;
      esc_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        stl_pkg::M_COMMENT: begin
          if (b == stl_pkg::CH_LF) mode_nxt = stl_pkg::M_SKIP;
        end
        stl_pkg::M_QUOTED: begin
          if (esc_r) begin
            esc_nxt = 1'b0;
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_TEXT;
            cmd.c_byte = (b == stl_pkg::CH_N) ? stl_pkg::CH_LF :
                         (b == stl_pkg::CH_T) ? stl_pkg::CH_TAB : b;
          end else if (b == qch_r) begin
            mode_nxt = stl_pkg::M_AFTERQ;
          end else if (b == stl_pkg::CH_BSL) begin
            esc_nxt = 1'b1;
          end else begin
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_TEXT; cmd.c_byte = b;
          end
        end
        stl_pkg::M_AFTERQ: begin
          cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_TEXT;
          cmd.f1_err = stl_pkg::is_delim(b) ? stl_pkg::ERR_NONE : stl_pkg::ERR_QUOTE;
          st = 1'b1;
        end
        stl_pkg::M_OPENER: begin
          if ((b == stl_pkg::CH_BSL) || stl_pkg::is_alnum(b) ||
              (b == stl_pkg::CH_SQ) || (b == stl_pkg::CH_DQ)) begin
            if (olen_r < LEN_W'(MAX_DELIM)) begin
              opn_nxt[olen_r[IDX_W-1:0]] = b;
              pat_nxt = pat_r << 8;
              pat_nxt[0] = stl_pkg::swap_slash(b);
              olen_nxt = olen_r + LEN_W'(1);
              if ((b == stl_pkg::CH_SQ) || (b == stl_pkg::CH_DQ)) begin
                wfill_nxt = '0;
                mode_nxt = stl_pkg::M_RAWFIRST;
              end
            end else begin
              cmd.fl_cnt = stl_pkg::CNT_W'(olen_r); cmd.fl_kind = stl_pkg::TK_NAME;
              cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_NAME; cmd.c_byte = b;
              mode_nxt = stl_pkg::M_NAMEBAD;
            end
          end else if (stl_pkg::is_delim(b)) begin
            cmd.fl_cnt = stl_pkg::CNT_W'(olen_r); cmd.fl_kind = stl_pkg::TK_NAME;
            cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_NAME;
            st = 1'b1;
          end else begin
            cmd.fl_cnt = stl_pkg::CNT_W'(olen_r); cmd.fl_kind = stl_pkg::TK_NAME;
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_NAME; cmd.c_byte = b;
            mode_nxt = stl_pkg::M_NAME;
          end
        end
        stl_pkg::M_RAWFIRST, stl_pkg::M_RAW: begin
          mode_nxt = stl_pkg::M_RAW;
          // drop a newline right after the opener
          if ((mode_r == stl_pkg::M_RAW) || (b != stl_pkg::CH_LF)) begin
            if (raw_shift) begin
              fl_src_win = 1'b1;
              cmd.fl_cnt = stl_pkg::CNT_W'(1); cmd.fl_kind = stl_pkg::TK_TEXT;
            end
            win_nxt = win_new;
            wfill_nxt = wpos + LEN_W'(1);
            if (raw_closed) begin
              cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_TEXT;
              wfill_nxt = '0;
              mode_nxt = stl_pkg::M_SKIP;
            end
          end
        end
        stl_pkg::M_SIGN, stl_pkg::M_INT, stl_pkg::M_INTOVF: begin
          if (stl_pkg::is_digit(b)) begin
            if (mode_r == stl_pkg::M_SIGN) mode_nxt = stl_pkg::M_INT;
            if (mode_r != stl_pkg::M_INTOVF) begin
              if (ovf) begin
                acc_nxt = lim;
                mode_nxt = stl_pkg::M_INTOVF;
              end else begin
                acc_nxt = prod[63:0];
              end
            end
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_INT; cmd.c_byte = b;
          end else if ((b == stl_pkg::CH_DOT) && (mode_r != stl_pkg::M_SIGN)) begin
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_REAL; cmd.c_byte = b;
            mode_nxt = stl_pkg::M_DOT;
          end else if (stl_pkg::is_delim(b)) begin
            cmd.f1_vld = 1'b1;
            if (mode_r == stl_pkg::M_SIGN) begin
              cmd.f1_kind = stl_pkg::TK_NAME;
            end else begin
              cmd.f1_kind = stl_pkg::TK_INT;
              cmd.f1_val = neg_r ? (64'd0 - acc_r) : acc_r;
              cmd.f1_err = (mode_r == stl_pkg::M_INTOVF) ? stl_pkg::ERR_OVF
                                                         : stl_pkg::ERR_NONE;
            end
            st = 1'b1;
          end else begin
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_NAME; cmd.c_byte = b;
            mode_nxt = stl_pkg::M_NAME;
          end
        end
        stl_pkg::M_DOT, stl_pkg::M_FRAC: begin
          if (stl_pkg::is_digit(b)) begin
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_REAL; cmd.c_byte = b;
            mode_nxt = stl_pkg::M_FRAC;
          end else if (stl_pkg::is_delim(b)) begin
            cmd.f1_vld = 1'b1;
            cmd.f1_kind = (mode_r == stl_pkg::M_FRAC) ? stl_pkg::TK_REAL : stl_pkg::TK_NAME;
            st = 1'b1;
          end else begin
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_NAME; cmd.c_byte = b;
            mode_nxt = stl_pkg::M_NAME;
          end
        end
        stl_pkg::M_NAME, stl_pkg::M_NAMEBAD: begin
          if (stl_pkg::is_delim(b)) begin
            cmd.f1_vld = 1'b1; cmd.f1_kind = stl_pkg::TK_NAME;
            cmd.f1_err = (mode_r == stl_pkg::M_NAMEBAD) ? stl_pkg::ERR_LONG
                                                        : stl_pkg::ERR_NONE;
            st = 1'b1;
          end else begin
            cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_NAME; cmd.c_byte = b;
          end
        end
        default: st = 1'b1;
      endcase
      // start a new token at this byte
      if (st) begin
        sline_nxt = line_nxt;
        mode_nxt = stl_pkg::M_SKIP;
        if (stl_pkg::is_space(b)) begin
          mode_nxt = stl_pkg::M_SKIP;
        end else if ((b == stl_pkg::CH_HASH) || (b == stl_pkg::CH_SEMI)) begin
          mode_nxt = stl_pkg::M_COMMENT;
        end else if ((b == stl_pkg::CH_LP) || (b == stl_pkg::CH_RP)) begin
          cmd.c_vld = 1'b1; cmd.c_byte = b;
          cmd.c_kind = (b == stl_pkg::CH_LP) ? stl_pkg::TK_OPEN : stl_pkg::TK_CLOSE;
          cmd.f2_vld = 1'b1; cmd.f2_kind = cmd.c_kind;
        end else if ((b == stl_pkg::CH_SQ) || (b == stl_pkg::CH_DQ)) begin
          qch_nxt = b; esc_nxt = 1'b0; mode_nxt = stl_pkg::M_QUOTED;
        end else if (b == stl_pkg::CH_BSL) begin
          opn_nxt[0] = b;
          pat_nxt[0] = stl_pkg::CH_SLASH;
          olen_nxt = LEN_W'(1);
          mode_nxt = stl_pkg::M_OPENER;
        end else if (stl_pkg::is_digit(b)) begin
          neg_nxt = 1'b0; acc_nxt = {60'b0, b[3:0]}; mode_nxt = stl_pkg::M_INT;
          cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_INT; cmd.c_byte = b;
        end else if ((b == stl_pkg::CH_PLUS) || (b == stl_pkg::CH_MINUS)) begin
          neg_nxt = (b == stl_pkg::CH_MINUS); acc_nxt = '0; mode_nxt = stl_pkg::M_SIGN;
          cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_INT; cmd.c_byte = b;
        end else begin
          cmd.c_vld = 1'b1; cmd.c_kind = stl_pkg::TK_NAME; cmd.c_byte = b;
          mode_nxt = stl_pkg::M_NAME;
        end
      end
    end
    cmd.line_a = sline_r;
    cmd.line_b = sline_nxt;
    cmd.line_e = line_nxt;
    push = take && ((cmd.fl_cnt != '0) || cmd.f1_vld || cmd.c_vld || cmd.f2_vld ||
                    cmd.eof_vld);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stl_pkg::M_SKIP;
      line_r <= 24'd1;
      sline_r <= '0;
      acc_r <= '0;
      neg_r <= 1'b0;
      qch_r <= '0;
      esc_r <= 1'b0;
      olen_r <= '0;
      wfill_r <= '0;
    end else if (take) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      sline_r <= sline_nxt;
      acc_r <= acc_nxt;
      neg_r <= neg_nxt;
      qch_r <= qch_nxt;
      esc_r <= esc_nxt;
      olen_r <= olen_nxt;
      wfill_r <= wfill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      opn_r <= opn_nxt;
      pat_r <= pat_nxt;
      win_r <= win_nxt;
    end
  end

  `STL_ASSERT_NOW(a_eof_push, take && in_ch.end_of_input, push)
  `STL_ASSERT_NOW(a_push_room, push, !q_full)
  `STL_ASSERT_NOW(a_raw_len, (mode_r == stl_pkg::M_RAW) || (mode_r == stl_pkg::M_RAWFIRST), (olen_r >= LEN_W'(2)) && (wfill_r <= olen_r))

endmodule

// File: hw/rtl/stl_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_queue
// Short request queue between the lexer front and the record sequencer.
// ---------------------------------------------------------------------------
`include "sexpr_token_lexer_unit_defines.svh"
module stl_queue #(
  parameter int MAX_DELIM = stl_pkg::MAX_DELIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  input  stl_pkg::cmd_t             wr_cmd,
  input  logic [MAX_DELIM-1:0][7:0] wr_data,
  input  logic                      pop,
  output stl_pkg::cmd_t             rd_cmd,
  output logic [MAX_DELIM-1:0][7:0] rd_data,
  output logic                      full,
  output logic                      empty
);
  localparam int QA_W  = $clog2(stl_pkg::QDEPTH);
  localparam int QC_W  = $clog2(stl_pkg::QDEPTH + 1);

  stl_pkg::cmd_t cmd_q [stl_pkg::QDEPTH];
  logic [MAX_DELIM-1:0][7:0] dat_q [stl_pkg::QDEPTH];
  logic [QA_W-1:0] wr_r, rd_r;
  logic [QC_W-1:0] cnt_r;

  assign full  = (cnt_r == QC_W'(stl_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rd_cmd  = cmd_q[rd_r];
  assign rd_data = dat_q[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q[wr_r] <= wr_cmd;
      dat_q[wr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + QA_W'(1);
      if (pop) rd_r <= rd_r + QA_W'(1);
      if (push && !pop) cnt_r <= cnt_r + QC_W'(1);
      else if (pop && !push) cnt_r <= cnt_r - QC_W'(1);
    end
  end

  `STL_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= QC_W'(stl_pkg::QDEPTH))
  `STL_ASSERT_NOW(a_pop_nonempty, pop, !empty)
  `STL_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + QC_W'(1))

endmodule

// File: hw/rtl/stl_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// stl_back
// Record sequencer: expands each request into result records, one a cycle while the record side is ready.
// ---------------------------------------------------------------------------
`include "sexpr_token_lexer_unit_defines.svh"
module stl_back #(
  parameter int MAX_DELIM = stl_pkg::MAX_DELIM_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  stl_pkg::cmd_t             hd_cmd,
  input  logic [MAX_DELIM-1:0][7:0] hd_data,
  output logic                      pop,
  stl_out_if.source                 out_ch
);
  localparam int IDX_W = $clog2(MAX_DELIM);
  localparam int CW    = stl_pkg::CNT_W;

  logic [CW-1:0] k_r, k_nxt, total, last_k, j;
  logic [3:0]    v;
  logic [1:0]    sel;
  logic [2:0]    seen;
  logic          load, is_last;
  logic          ovld_r;
  logic          rk_r, rk_nxt;
  logic [2:0]    tk_r, tk_nxt;
  logic [7:0]    db_r, db_nxt;
  logic [23:0]   ln_r, ln_nxt;
  logic [63:0]   iv_r, iv_nxt;
  logic [1:0]    er_r, er_nxt;
  logic          la_r;

  assign v = {hd_cmd.eof_vld, hd_cmd.f2_vld, hd_cmd.c_vld, hd_cmd.f1_vld};
  assign total = hd_cmd.fl_cnt + CW'(v[0]) + CW'(v[1]) + CW'(v[2]) + CW'(v[3]);
  // records beyond the per-item limit are dropped
  assign last_k = (total > CW'(stl_pkg::MAX_RESULTS)) ? CW'(stl_pkg::MAX_RESULTS - 1)
                                                      : total - CW'(1);
  assign is_last = (k_r == last_k);
  assign load = !q_empty && (!ovld_r || out_ch.ready);
  assign pop = load && is_last;
  assign k_nxt = is_last ? '0 : k_r + CW'(1);
  assign j = k_r - hd_cmd.fl_cnt;

  always_comb begin
    sel = 2'd0;
    seen = 3'd0;
    for (int s = 0; s < 4; s++) begin
      if (v[s]) begin
        if (CW'(seen) == j) sel = 2'(s);
        seen = seen + 3'd1;
      end
    end
    rk_nxt = stl_pkg::RK_DATA;
    tk_nxt = hd_cmd.fl_kind;
    db_nxt = hd_data[k_r[IDX_W-1:0]];
    ln_nxt = hd_cmd.line_a;
    iv_nxt = '0;
    er_nxt = stl_pkg::ERR_NONE;
    if (k_r >= hd_cmd.fl_cnt) begin
      db_nxt = '0;
      case (sel)
        2'd0: begin
          rk_nxt = stl_pkg::RK_END; tk_nxt = hd_cmd.f1_kind;
          iv_nxt = hd_cmd.f1_val; er_nxt = hd_cmd.f1_err;
        end
        2'd1: begin
          tk_nxt = hd_cmd.c_kind; db_nxt = hd_cmd.c_byte; ln_nxt = hd_cmd.line_b;
        end
        2'd2: begin
          rk_nxt = stl_pkg::RK_END; tk_nxt = hd_cmd.f2_kind; ln_nxt = hd_cmd.line_b;
        end
        default: begin
          rk_nxt = stl_pkg::RK_END; tk_nxt = stl_pkg::TK_EOF; ln_nxt = hd_cmd.line_e;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
      k_r <= '0;
    end else begin
      if (load) begin
        ovld_r <= 1'b1;
        k_r <= k_nxt;
      end else if (out_ch.ready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rk_r <= rk_nxt;
      tk_r <= tk_nxt;
      db_r <= db_nxt;
      ln_r <= ln_nxt;
      iv_r <= iv_nxt;
      er_r <= er_nxt;
      la_r <= is_last;
    end
  end

  assign out_ch.valid       = ovld_r;
  assign out_ch.record_kind = rk_r;
  assign out_ch.token_kind  = tk_r;
  assign out_ch.data_byte   = db_r;
  assign out_ch.token_line  = ln_r;
  assign out_ch.int_value   = iv_r;
  assign out_ch.error_code  = er_r;
  assign out_ch.last        = la_r;

  `STL_ASSERT_NOW(a_mid_head, k_r != '0, !q_empty)
  `STL_ASSERT_NEXT(a_load_valid, load, ovld_r)
  `STL_ASSERT_NOW(a_data_noerr, ovld_r && (rk_r == stl_pkg::RK_DATA), er_r == stl_pkg::ERR_NONE)

endmodule

// File: hw/rtl/sexpr_token_lexer_unit.sv
`timescale 1ns / 1ps
// Path: an accepted item is written to the request queue; its records leave
// through the output register. Throughput: one byte per cycle while each makes
// at most one record and the record side is ready; the four-entry request queue
// absorbs items of several records, which hold the sequencer, before input stalls.
// Reset: synchronous active-low rst_n clears lexer state (line count to 1),
// empties the queue and drops any record in the output register.
// ---------------------------------------------------------------------------
// sexpr_token_lexer_unit
// S-expression token lexer: byte in, token records out.
// ---------------------------------------------------------------------------
module sexpr_token_lexer_unit #(
  parameter int MAX_DELIM = stl_pkg::MAX_DELIM_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  stl_in_if.sink     in_ch,
  stl_out_if.source  out_ch
);
  stl_pkg::cmd_t             f_cmd, h_cmd;
  logic [MAX_DELIM-1:0][7:0] f_data, h_data;
  logic                      push, pop, q_full, q_empty;

  stl_front #(.MAX_DELIM(MAX_DELIM)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_full(q_full),
    .push(push), .cmd(f_cmd), .fl_data(f_data)
  );

  stl_queue #(.MAX_DELIM(MAX_DELIM)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .wr_cmd(f_cmd), .wr_data(f_data),
    .pop(pop), .rd_cmd(h_cmd), .rd_data(h_data), .full(q_full), .empty(q_empty)
  );

  stl_back #(.MAX_DELIM(MAX_DELIM)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .hd_cmd(h_cmd), .hd_data(h_data),
    .pop(pop), .out_ch(out_ch)
  );

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Token lexer bench: a directed byte table, then random token streams.
// Every record is checked against a behavioral lexer kept in step with the
// accepted input, under random gaps on the byte side and stalls on the
// record side.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int MAXD = stl_pkg::MAX_DELIM_DEF;

  typedef struct {
    logic       rk;
    logic [2:0] tk;
    logic [7:0] db;
    logic [23:0] ln;
    logic [63:0] val;
    logic [1:0] err;
    logic       lst;
  } rec_t;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
    logic       chk;
    logic [2:0] tk;
    logic [1:0] err;
  } byte_req_t;

  logic clk;
  logic rst_n;

  stl_in_if  in_ch ();
  stl_out_if out_ch ();

  sexpr_token_lexer_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // lexer shadow state
  stl_pkg::lex_mode_t lx_mode;
  logic [23:0] lx_line;
  logic [23:0] lx_tok_line;
  logic [63:0] lx_acc;
  logic        lx_neg;
  logic [7:0]  lx_quote;
  logic        lx_esc;
  logic [7:0]  lx_opener [MAXD];
  int          lx_olen;
  logic [7:0]  lx_win [MAXD];
  int          lx_wfill;

  rec_t      step_recs[$];
  rec_t      pending_recs[$];
  byte_req_t byte_reqs[$];
  int        mismatch_cnt;
  bit        tx_idle_on;
  bit        rx_stall_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("** sexpr_token_lexer_unit: FAILED **");
    $finish;
  end

  function automatic bit ws(input logic [7:0] b);
    return b == stl_pkg::CH_SP || (b >= stl_pkg::CH_TAB && b <= stl_pkg::CH_CR);
  endfunction

  function automatic bit brk(input logic [7:0] b);
    return ws(b) || b == stl_pkg::CH_LP || b == stl_pkg::CH_RP;
  endfunction

  function automatic bit dig(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit alnum(input logic [7:0] b);
    return dig(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic [7:0] mirror(input logic [7:0] b);
    if (b == stl_pkg::CH_SLASH) return stl_pkg::CH_BSL;
    if (b == stl_pkg::CH_BSL) return stl_pkg::CH_SLASH;
    return b;
  endfunction

  function automatic void put(input logic rk, input logic [2:0] tk, input logic [7:0] d,
                              input logic [23:0] ln, input logic [63:0] v,
                              input logic [1:0] e);
    rec_t r;
    r = '{rk, tk, d, ln, v, e, 1'b0};
    if (step_recs.size() < stl_pkg::MAX_RESULTS) step_recs.push_back(r);
  endfunction

  function automatic void body(input logic [2:0] tk, input logic [7:0] b);
    put(stl_pkg::RK_DATA, tk, b, lx_tok_line, '0, stl_pkg::ERR_NONE);
  endfunction

  function automatic void close_tok(input logic [2:0] tk, input logic [63:0] v,
                                    input logic [1:0] e);
    put(stl_pkg::RK_END, tk, 8'h00, lx_tok_line, v, e);
  endfunction

  function automatic void dump_opener();
    for (int i = 0; i < lx_olen && i < MAXD; i++) body(stl_pkg::TK_NAME, lx_opener[i]);
  endfunction

  function automatic void take_digit(input logic [7:0] b);
    logic [63:0] d, lim;
    d = 64'(b - "0");
    lim = lx_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    if (lx_mode == stl_pkg::M_INTOVF) return;
    if (lx_acc > (lim - d) / 10) begin
      lx_acc = lim;
      lx_mode = stl_pkg::M_INTOVF;
    end else begin
      lx_acc = lx_acc * 10 + d;
    end
  endfunction

  function automatic logic [63:0] int_signed();
    return lx_neg ? (64'd0 - lx_acc) : lx_acc;
  endfunction

  function automatic void begin_tok(input logic [7:0] b);
    lx_tok_line = lx_line;
    lx_mode = stl_pkg::M_SKIP;
    if (ws(b)) return;
    if (b == stl_pkg::CH_HASH || b == stl_pkg::CH_SEMI) begin
      lx_mode = stl_pkg::M_COMMENT;
    end else if (b == stl_pkg::CH_LP) begin
      body(stl_pkg::TK_OPEN, b);
      close_tok(stl_pkg::TK_OPEN, '0, stl_pkg::ERR_NONE);
    end else if (b == stl_pkg::CH_RP) begin
      body(stl_pkg::TK_CLOSE, b);
      close_tok(stl_pkg::TK_CLOSE, '0, stl_pkg::ERR_NONE);
    end else if (b == stl_pkg::CH_SQ || b == stl_pkg::CH_DQ) begin
      lx_quote = b;
      lx_esc = 1'b0;
      lx_mode = stl_pkg::M_QUOTED;
    end else if (b == stl_pkg::CH_BSL) begin
      lx_opener[0] = b;
      lx_olen = 1;
      lx_mode = stl_pkg::M_OPENER;
    end else if (dig(b)) begin
      lx_neg = 1'b0;
      lx_acc = '0;
      lx_mode = stl_pkg::M_INT;
      take_digit(b);
      body(stl_pkg::TK_INT, b);
    end else if (b == stl_pkg::CH_PLUS || b == stl_pkg::CH_MINUS) begin
      lx_neg = (b == stl_pkg::CH_MINUS);
      lx_acc = '0;
      lx_mode = stl_pkg::M_SIGN;
      body(stl_pkg::TK_INT, b);
    end else begin
      body(stl_pkg::TK_NAME, b);
      lx_mode = stl_pkg::M_NAME;
    end
  endfunction

  function automatic void raw_in(input logic [7:0] b);
    int  len;
    bit  hit;
    len = (lx_olen == 0 || lx_olen > MAXD) ? MAXD : lx_olen;
    if (lx_wfill >= len) begin
      body(stl_pkg::TK_TEXT, lx_win[0]);
      for (int i = 0; i < len - 1; i++) lx_win[i] = lx_win[i+1];
      lx_wfill = len - 1;
    end
    lx_win[lx_wfill] = b;
    lx_wfill++;
    hit = (lx_wfill == len);
    for (int i = 0; i < len && hit; i++)
      if (lx_win[i] != mirror(lx_opener[len-1-i])) hit = 0;
    if (hit) begin
      close_tok(stl_pkg::TK_TEXT, '0, stl_pkg::ERR_NONE);
      lx_wfill = 0;
      lx_mode = stl_pkg::M_SKIP;
    end
  endfunction

  function automatic void opener_in(input logic [7:0] b);
    if (b == stl_pkg::CH_BSL || alnum(b) || b == stl_pkg::CH_SQ || b == stl_pkg::CH_DQ) begin
      if (lx_olen < MAXD) begin
        lx_opener[lx_olen] = b;
        lx_olen++;
        if (b == stl_pkg::CH_SQ || b == stl_pkg::CH_DQ) begin
          lx_wfill = 0;
          lx_mode = stl_pkg::M_RAWFIRST;
        end
      end else begin
        dump_opener();
        body(stl_pkg::TK_NAME, b);
        lx_mode = stl_pkg::M_NAMEBAD;
      end
    end else if (brk(b)) begin
      dump_opener();
      close_tok(stl_pkg::TK_NAME, '0, stl_pkg::ERR_NONE);
      begin_tok(b);
    end else begin
      dump_opener();
      body(stl_pkg::TK_NAME, b);
      lx_mode = stl_pkg::M_NAME;
    end
  endfunction

  function automatic void byte_in(input logic [7:0] b);
    stl_pkg::lex_mode_t m;
    m = lx_mode;
    if (b == stl_pkg::CH_LF && lx_line != stl_pkg::LINE_TOP) lx_line++;
    case (m)
      stl_pkg::M_COMMENT: if (b == stl_pkg::CH_LF) lx_mode = stl_pkg::M_SKIP;
      stl_pkg::M_QUOTED: begin
        if (lx_esc) begin
          lx_esc = 1'b0;
          body(stl_pkg::TK_TEXT, b == stl_pkg::CH_N ? stl_pkg::CH_LF :
                                 (b == stl_pkg::CH_T ? stl_pkg::CH_TAB : b));
        end else if (b == lx_quote) lx_mode = stl_pkg::M_AFTERQ;
        else if (b == stl_pkg::CH_BSL) lx_esc = 1'b1;
        else body(stl_pkg::TK_TEXT, b);
      end
      stl_pkg::M_AFTERQ: begin
        close_tok(stl_pkg::TK_TEXT, '0, brk(b) ? stl_pkg::ERR_NONE : stl_pkg::ERR_QUOTE);
        begin_tok(b);
      end
      stl_pkg::M_OPENER: opener_in(b);
      stl_pkg::M_RAWFIRST: begin
        lx_mode = stl_pkg::M_RAW;
        if (b != stl_pkg::CH_LF) raw_in(b);
      end
      stl_pkg::M_RAW: raw_in(b);
      stl_pkg::M_SIGN, stl_pkg::M_INT, stl_pkg::M_INTOVF: begin
        if (dig(b)) begin
          if (m == stl_pkg::M_SIGN) lx_mode = stl_pkg::M_INT;
          take_digit(b);
          body(stl_pkg::TK_INT, b);
        end else if (b == stl_pkg::CH_DOT && m != stl_pkg::M_SIGN) begin
          body(stl_pkg::TK_REAL, b);
          lx_mode = stl_pkg::M_DOT;
        end else if (brk(b)) begin
          if (m == stl_pkg::M_SIGN) close_tok(stl_pkg::TK_NAME, '0, stl_pkg::ERR_NONE);
          else close_tok(stl_pkg::TK_INT, int_signed(),
                         m == stl_pkg::M_INTOVF ? stl_pkg::ERR_OVF : stl_pkg::ERR_NONE);
          begin_tok(b);
        end else begin
          body(stl_pkg::TK_NAME, b);
          lx_mode = stl_pkg::M_NAME;
        end
      end
      stl_pkg::M_DOT, stl_pkg::M_FRAC: begin
        if (dig(b)) begin
          body(stl_pkg::TK_REAL, b);
          lx_mode = stl_pkg::M_FRAC;
        end else if (brk(b)) begin
          close_tok(m == stl_pkg::M_FRAC ? stl_pkg::TK_REAL : stl_pkg::TK_NAME, '0,
                    stl_pkg::ERR_NONE);
          begin_tok(b);
        end else begin
          body(stl_pkg::TK_NAME, b);
          lx_mode = stl_pkg::M_NAME;
        end
      end
      stl_pkg::M_NAME, stl_pkg::M_NAMEBAD: begin
        if (brk(b)) begin
          close_tok(stl_pkg::TK_NAME, '0,
                    m == stl_pkg::M_NAMEBAD ? stl_pkg::ERR_LONG : stl_pkg::ERR_NONE);
          begin_tok(b);
        end else body(stl_pkg::TK_NAME, b);
      end
      default: begin_tok(b);
    endcase
  endfunction

  function automatic void input_end();
    int n;
    case (lx_mode)
      stl_pkg::M_QUOTED: close_tok(stl_pkg::TK_TEXT, '0, stl_pkg::ERR_QUOTE);
      stl_pkg::M_AFTERQ: close_tok(stl_pkg::TK_TEXT, '0, stl_pkg::ERR_NONE);
      stl_pkg::M_OPENER: begin
        dump_opener();
        close_tok(stl_pkg::TK_NAME, '0, stl_pkg::ERR_NONE);
      end
      stl_pkg::M_RAWFIRST, stl_pkg::M_RAW: begin
        n = lx_wfill < MAXD ? lx_wfill : MAXD;
        for (int i = 0; i < n; i++) body(stl_pkg::TK_TEXT, lx_win[i]);
        close_tok(stl_pkg::TK_TEXT, '0, stl_pkg::ERR_NONE);
      end
      stl_pkg::M_SIGN, stl_pkg::M_DOT, stl_pkg::M_NAME:
        close_tok(stl_pkg::TK_NAME, '0, stl_pkg::ERR_NONE);
      stl_pkg::M_NAMEBAD: close_tok(stl_pkg::TK_NAME, '0, stl_pkg::ERR_LONG);
      stl_pkg::M_INT: close_tok(stl_pkg::TK_INT, int_signed(), stl_pkg::ERR_NONE);
      stl_pkg::M_INTOVF: close_tok(stl_pkg::TK_INT, int_signed(), stl_pkg::ERR_OVF);
      stl_pkg::M_FRAC: close_tok(stl_pkg::TK_REAL, '0, stl_pkg::ERR_NONE);
      default: ;
    endcase
    put(stl_pkg::RK_END, stl_pkg::TK_EOF, 8'h00, lx_line, '0, stl_pkg::ERR_NONE);
    lx_mode = stl_pkg::M_SKIP;
    lx_wfill = 0;
    lx_esc = 1'b0;
  endfunction

  function automatic void lexer_reset();
    lx_mode = stl_pkg::M_SKIP;
    lx_line = 24'd1;
    lx_tok_line = '0;
    lx_acc = '0;
    lx_neg = 1'b0;
    lx_quote = '0;
    lx_esc = 1'b0;
    lx_olen = 0;
    lx_wfill = 0;
    for (int i = 0; i < MAXD; i++) begin
      lx_opener[i] = '0;
      lx_win[i] = '0;
    end
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    mismatch_cnt++;
  endtask

  // Advance the shadow lexer by one request and queue its records.
  task automatic lex_predict(input byte_req_t q);
    step_recs = {};
    if (q.eoi) input_end();
    else byte_in(q.b);
    if (step_recs.size() > 0) begin
      step_recs[step_recs.size()-1].lst = 1'b1;
      if (q.chk) begin
        if (step_recs[0].tk != q.tk) flag_mismatch("table kind", step_recs[0].tk, q.tk);
        if (step_recs[0].err != q.err) flag_mismatch("table error", step_recs[0].err, q.err);
      end
    end
    foreach (step_recs[i]) pending_recs.push_back(step_recs[i]);
  endtask

  function automatic void add_b(input logic [7:0] b);
    byte_reqs.push_back('{b, 1'b0, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE});
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic eoi, input logic chk,
                                  input logic [2:0] tk, input logic [1:0] err);
    byte_reqs.push_back('{b, eoi, chk, tk, err});
  endfunction

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(0, 61);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("a" + r - 10);
    return 8'("A" + r - 36);
  endfunction

  function automatic logic [7:0] pick_gap();
    case ($urandom_range(0, 5))
      0: return stl_pkg::CH_LF;
      1: return stl_pkg::CH_TAB;
      2: return stl_pkg::CH_LP;
      3: return stl_pkg::CH_RP;
      4: return stl_pkg::CH_CR;
      default: return stl_pkg::CH_SP;
    endcase
  endfunction

  function automatic void gen_token();
    logic [7:0] ob[$];
    logic [7:0] qc, c;
    int n;
    case ($urandom_range(0, 11))
      0: add_b(stl_pkg::CH_LP);
      1: add_b(stl_pkg::CH_RP);
      2, 3: begin
        if ($urandom_range(0, 2) == 0)
          add_b($urandom_range(0, 1) ? stl_pkg::CH_MINUS : stl_pkg::CH_PLUS);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(18, 21) : $urandom_range(0, 4);
        repeat (n) add_b(8'("0" + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) begin
          add_b(stl_pkg::CH_DOT);
          repeat ($urandom_range(0, 3)) add_b(8'("0" + $urandom_range(0, 9)));
        end
      end
      4: repeat ($urandom_range(1, 5)) add_b(pick_alnum());
      5, 6: begin
        qc = $urandom_range(0, 1) ? stl_pkg::CH_SQ : stl_pkg::CH_DQ;
        add_b(qc);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            add_b(stl_pkg::CH_BSL);
            case ($urandom_range(0, 2))
              0: add_b(stl_pkg::CH_N);
              1: add_b(stl_pkg::CH_T);
              default: add_b(8'($urandom_range(0, 255)));
            endcase
          end else begin
            c = 8'($urandom_range(0, 255));
            if (c == qc || c == stl_pkg::CH_BSL) c = "q";
            add_b(c);
          end
        end
        add_b(qc);
        if ($urandom_range(0, 4) == 0) add_b(pick_alnum());
      end
      7, 8: begin
        ob.push_back(stl_pkg::CH_BSL);
        n = ($urandom_range(0, 7) == 0) ? MAXD : $urandom_range(0, MAXD - 2);
        repeat (n) ob.push_back($urandom_range(0, 3) == 0 ? stl_pkg::CH_BSL : pick_alnum());
        ob.push_back($urandom_range(0, 1) ? stl_pkg::CH_SQ : stl_pkg::CH_DQ);
        foreach (ob[i]) add_b(ob[i]);
        if ($urandom_range(0, 2) == 0) add_b(stl_pkg::CH_LF);
        repeat ($urandom_range(0, 6)) add_b(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 5) != 0)
          for (int i = ob.size() - 1; i >= 0; i--) add_b(mirror(ob[i]));
      end
      9: begin
        add_b($urandom_range(0, 1) ? stl_pkg::CH_HASH : stl_pkg::CH_SEMI);
        repeat ($urandom_range(0, 4)) add_b(pick_alnum());
        add_b(stl_pkg::CH_LF);
      end
      10: repeat ($urandom_range(1, 3)) add_b(8'($urandom_range(0, 255)));
      default: add_row(8'h00, 1'b1, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE);
    endcase
    if ($urandom_range(0, 5) != 0) add_b(pick_gap());
  endfunction

  // Record side: random stalls, then hold ready until a record is taken.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      n = rx_stall_on ? $urandom_range(0, 19) : 0;
      if (n > 0) begin
        out_ch.ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    rec_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_recs.size() == 0) begin
        flag_mismatch("unexpected record", out_ch.data_byte, 0);
      end else begin
        w = pending_recs.pop_front();
        if (out_ch.record_kind !== w.rk) flag_mismatch("record_kind", out_ch.record_kind, w.rk);
        if (out_ch.token_kind !== w.tk) flag_mismatch("token_kind", out_ch.token_kind, w.tk);
        if (out_ch.data_byte !== w.db) flag_mismatch("data_byte", out_ch.data_byte, w.db);
        if (out_ch.token_line !== w.ln) flag_mismatch("token_line", out_ch.token_line, w.ln);
        if (out_ch.int_value !== w.val) flag_mismatch("int_value", out_ch.int_value, w.val);
        if (out_ch.error_code !== w.err) flag_mismatch("error_code", out_ch.error_code, w.err);
        if (out_ch.last !== w.lst) flag_mismatch("last", out_ch.last, w.lst);
      end
    end
  end

  initial begin
    byte_req_t q;
    int n, wait_cnt, k;
    mismatch_cnt = 0;
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    in_ch.end_of_input = 1'b0;
    lexer_reset();

    // Directed table: parens, quoted text with a bad follower, an opener too long,
    // zero and all-ones bytes, end of input.
    add_row(stl_pkg::CH_LP,  1'b0, 1'b1, stl_pkg::TK_OPEN,  stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_RP,  1'b0, 1'b1, stl_pkg::TK_CLOSE, stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_DQ,  1'b0, 1'b0, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    add_row("a",             1'b0, 1'b1, stl_pkg::TK_TEXT,  stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_BSL, 1'b0, 1'b0, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_N,   1'b0, 1'b0, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_DQ,  1'b0, 1'b0, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    add_row("x",             1'b0, 1'b1, stl_pkg::TK_TEXT,  stl_pkg::ERR_QUOTE);
    add_row(stl_pkg::CH_LF,  1'b0, 1'b1, stl_pkg::TK_NAME,  stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_BSL, 1'b0, 1'b0, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    for (int i = 0; i < 7; i++) add_b(8'("a" + i));
    add_b("h");
    add_row(stl_pkg::CH_SP,  1'b0, 1'b1, stl_pkg::TK_NAME,  stl_pkg::ERR_LONG);
    add_row(8'h00,           1'b0, 1'b1, stl_pkg::TK_NAME,  stl_pkg::ERR_NONE);
    add_row(8'hFF,           1'b0, 1'b0, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_MINUS, 1'b0, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE);
    add_row(stl_pkg::CH_SP,  1'b0, 1'b1, stl_pkg::TK_NAME,  stl_pkg::ERR_NONE);
    add_row(8'h00,           1'b1, 1'b1, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    add_row(8'hFF,           1'b1, 1'b1, stl_pkg::TK_EOF,   stl_pkg::ERR_NONE);
    while (byte_reqs.size() < 250) gen_token();
    add_row(8'h00, 1'b1, 1'b0, stl_pkg::TK_EOF, stl_pkg::ERR_NONE);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    k = 0;
    while (byte_reqs.size() > 0) begin
      // switch idling style every 40 requests
      if (k % 40 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_stall_on = $urandom_range(0, 3) != 0;
      end
      k++;
      q = byte_reqs.pop_front();
      n = tx_idle_on ? $urandom_range(0, 19) : 0;
      if (n > 0) begin
        in_ch.valid = 1'b0;
        repeat (n) @(negedge clk);
      end
      in_ch.valid = 1'b1;
      in_ch.in_byte = q.b;
      in_ch.end_of_input = q.eoi;
      do @(posedge clk); while (!in_ch.ready);
      lex_predict(q);
      @(negedge clk);
    end
    in_ch.valid = 1'b0;

    wait_cnt = 0;
    while (pending_recs.size() > 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (50) @(posedge clk);
    if (mismatch_cnt == 0 && pending_recs.size() == 0)
      $display("** sexpr_token_lexer_unit: PASSED **");
    else
      $display("** sexpr_token_lexer_unit: FAILED **");
    $finish;
  end

endmodule
